// ===== sv/bfs_pkg.sv =====
// package: shared types, command codes and controller encodings for the bfs core
package bfs_pkg;

    localparam logic [2:0] CMD_CLEAR    = 3'd0;
    localparam logic [2:0] CMD_ADD_EDGE = 3'd1;
    localparam logic [2:0] CMD_ADD_SRC  = 3'd2;
    localparam logic [2:0] CMD_RUN      = 3'd3;
    localparam logic [2:0] CMD_QUERY    = 3'd4;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_EDGE_FULL = 2'd1;
    localparam logic [1:0] ST_SRC_FULL  = 2'd2;

    typedef struct packed {
        logic [2:0] command;
        logic [9:0] node_a;
        logic [9:0] node_b;
        logic       use_target;
    } in_t;

    typedef struct packed {
        logic [1:0]  status;
        logic        reached;
        logic [9:0]  distance;
        logic [31:0] path_count;
        logic [10:0] nodes_dequeued;
    } out_t;

    typedef enum logic [4:0] {
        S_RST_SWEEP,
        S_IDLE,
        S_DECODE,
        S_SWEEP,
        S_SEED_CHK,
        S_SEED_WAIT1,
        S_SEED_WAIT2,
        S_POP_CHK,
        S_POP_WAIT,
        S_U_WAIT,
        S_E_CHK,
        S_E_WAIT,
        S_V_WAIT,
        S_Q_WAIT,
        S_AE_1,
        S_AE_2,
        S_FINISH
    } ctl_state_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_CLR_CNT,
        OP_SRC,
        OP_SWEEP,
        OP_SEED_RD,
        OP_SEED_INFO,
        OP_SEED_WR,
        OP_POP,
        OP_U_RD,
        OP_U_LATCH,
        OP_E_RD,
        OP_V_RD,
        OP_V_UPD,
        OP_QRD,
        OP_Q_RES,
        OP_AE1,
        OP_AE2,
        OP_EDGE_FULL,
        OP_EMIT
    } dp_op_t;

    typedef struct packed {
        logic [2:0] cmd;
        logic       a_ok;
        logic       ab_ok;
        logic       edge_full;
        logic       sweep_last;
        logic       seed_more;
        logic       queue_more;
        logic       hit_target;
        logic       edge_more;
        logic       out_free;
    } dp_stat_t;

endpackage

// ===== sv/bfs_ctrl.sv =====
// controller: state machine that sequences the datapath operations
module bfs_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  bfs_pkg::dp_stat_t stat,
    output bfs_pkg::dp_op_t   op
);

    bfs_pkg::ctl_state_t state_reg;
    bfs_pkg::ctl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bfs_pkg::S_RST_SWEEP;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        op         = bfs_pkg::OP_NONE;
        in_ready   = 1'b0;
        case (state_reg)
            bfs_pkg::S_RST_SWEEP:
            begin
                op = bfs_pkg::OP_SWEEP;
                if (stat.sweep_last)
                begin
                    state_next = bfs_pkg::S_IDLE;
                end
            end
            bfs_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    op         = bfs_pkg::OP_LOAD;
                    state_next = bfs_pkg::S_DECODE;
                end
            end
            bfs_pkg::S_DECODE:
            begin
                case (stat.cmd)
                    bfs_pkg::CMD_CLEAR:
                    begin
                        op         = bfs_pkg::OP_CLR_CNT;
                        state_next = bfs_pkg::S_SWEEP;
                    end
                    bfs_pkg::CMD_ADD_EDGE:
                    begin
                        if (stat.edge_full)
                        begin
                            op         = bfs_pkg::OP_EDGE_FULL;
                            state_next = bfs_pkg::S_FINISH;
                        end
                        else if (stat.ab_ok)
                        begin
                            op         = bfs_pkg::OP_AE1;
                            state_next = bfs_pkg::S_AE_2;
                        end
                        else
                        begin
                            state_next = bfs_pkg::S_FINISH;
                        end
                    end
                    bfs_pkg::CMD_ADD_SRC:
                    begin
                        op         = bfs_pkg::OP_SRC;
                        state_next = bfs_pkg::S_FINISH;
                    end
                    bfs_pkg::CMD_RUN:
                    begin
                        state_next = bfs_pkg::S_SWEEP;
                    end
                    bfs_pkg::CMD_QUERY:
                    begin
                        if (stat.a_ok)
                        begin
                            op         = bfs_pkg::OP_QRD;
                            state_next = bfs_pkg::S_Q_WAIT;
                        end
                        else
                        begin
                            state_next = bfs_pkg::S_FINISH;
                        end
                    end
                    default:
                    begin
                        state_next = bfs_pkg::S_FINISH;
                    end
                endcase
            end
            bfs_pkg::S_SWEEP:
            begin
                op = bfs_pkg::OP_SWEEP;
                if (stat.sweep_last)
                begin
                    state_next = (stat.cmd == bfs_pkg::CMD_RUN) ? bfs_pkg::S_SEED_CHK
                                                                : bfs_pkg::S_FINISH;
                end
            end
            bfs_pkg::S_SEED_CHK:
            begin
                if (stat.seed_more)
                begin
                    op         = bfs_pkg::OP_SEED_RD;
                    state_next = bfs_pkg::S_SEED_WAIT1;
                end
                else
                begin
                    state_next = bfs_pkg::S_POP_CHK;
                end
            end
            bfs_pkg::S_SEED_WAIT1:
            begin
                op         = bfs_pkg::OP_SEED_INFO;
                state_next = bfs_pkg::S_SEED_WAIT2;
            end
            bfs_pkg::S_SEED_WAIT2:
            begin
                op         = bfs_pkg::OP_SEED_WR;
                state_next = bfs_pkg::S_SEED_CHK;
            end
            bfs_pkg::S_POP_CHK:
            begin
                if (stat.queue_more)
                begin
                    op         = bfs_pkg::OP_POP;
                    state_next = bfs_pkg::S_POP_WAIT;
                end
                else
                begin
                    state_next = bfs_pkg::S_FINISH;
                end
            end
            bfs_pkg::S_POP_WAIT:
            begin
                op         = bfs_pkg::OP_U_RD;
                state_next = stat.hit_target ? bfs_pkg::S_FINISH : bfs_pkg::S_U_WAIT;
            end
            bfs_pkg::S_U_WAIT:
            begin
                op         = bfs_pkg::OP_U_LATCH;
                state_next = bfs_pkg::S_E_CHK;
            end
            bfs_pkg::S_E_CHK:
            begin
                if (stat.edge_more)
                begin
                    op         = bfs_pkg::OP_E_RD;
                    state_next = bfs_pkg::S_E_WAIT;
                end
                else
                begin
                    state_next = bfs_pkg::S_POP_CHK;
                end
            end
            bfs_pkg::S_E_WAIT:
            begin
                op         = bfs_pkg::OP_V_RD;
                state_next = bfs_pkg::S_V_WAIT;
            end
            bfs_pkg::S_V_WAIT:
            begin
                op         = bfs_pkg::OP_V_UPD;
                state_next = bfs_pkg::S_E_CHK;
            end
            bfs_pkg::S_Q_WAIT:
            begin
                op         = bfs_pkg::OP_Q_RES;
                state_next = bfs_pkg::S_FINISH;
            end
            bfs_pkg::S_AE_1:
            begin
                op         = bfs_pkg::OP_AE1;
                state_next = bfs_pkg::S_AE_2;
            end
            bfs_pkg::S_AE_2:
            begin
                op         = bfs_pkg::OP_AE2;
                state_next = bfs_pkg::S_FINISH;
            end
            bfs_pkg::S_FINISH:
            begin
                if (stat.out_free)
                begin
                    op         = bfs_pkg::OP_EMIT;
                    state_next = bfs_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = bfs_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ===== sv/bfs_dpath.sv =====
// datapath: graph, source, node and queue memories, counters and result register
module bfs_dpath #(
    parameter int MAX_NODES   = 1024,
    parameter int MAX_EDGES   = 4096,
    parameter int COUNT_WIDTH = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  bfs_pkg::dp_op_t   op,
    output bfs_pkg::dp_stat_t stat,
    input  bfs_pkg::in_t      in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output bfs_pkg::out_t     out_data,
    input  logic              cfg_we,
    input  logic              cfg_wdata
);

    localparam int NW  = $clog2(MAX_NODES);
    localparam int CW  = $clog2(MAX_NODES + 1);
    localparam int EW  = $clog2(MAX_EDGES + 1);
    localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int IW  = 1 + NW + COUNT_WIDTH;
    localparam logic [EW-1:0] EMPTY = EW'(MAX_EDGES);

    // memories
    logic [NW-1:0] edge_dest_mem [MAX_EDGES];
    logic [EW-1:0] edge_next_mem [MAX_EDGES];
    logic [EW-1:0] adj_head_mem  [MAX_NODES];
    logic [EW-1:0] adj_tail_mem  [MAX_NODES];
    logic [NW-1:0] source_mem    [MAX_NODES];
    logic [IW-1:0] info_mem      [MAX_NODES];
    logic [NW-1:0] queue_mem     [MAX_NODES];

    // registered read data
    logic [NW-1:0] dest_q;
    logic [EW-1:0] next_q;
    logic [EW-1:0] head_q;
    logic [EW-1:0] tail_q;
    logic [NW-1:0] src_q;
    logic [IW-1:0] info_q;
    logic [NW-1:0] queue_q;

    // memory port controls
    logic          dest_we;
    logic [EAW-1:0] dest_wa;
    logic          dest_re;
    logic [EAW-1:0] dest_ra;
    logic          next_we;
    logic [EAW-1:0] next_wa;
    logic [EW-1:0] next_wd;
    logic          ah_we;
    logic [NW-1:0] ah_wa;
    logic [EW-1:0] ah_wd;
    logic          ah_re;
    logic          at_we;
    logic [NW-1:0] at_wa;
    logic [EW-1:0] at_wd;
    logic          at_re;
    logic          src_we;
    logic          src_re;
    logic          info_we;
    logic [NW-1:0] info_wa;
    logic [IW-1:0] info_wd;
    logic          info_re;
    logic [NW-1:0] info_ra;
    logic          q_we;
    logic          q_re;

    // control registers
    logic [2:0]             cmd_reg;
    logic [9:0]             a_reg;
    logic [9:0]             b_reg;
    logic                   use_t_reg;
    logic                   graph_sweep_reg;
    logic [NW-1:0]          sweep_cnt_reg;
    logic [EW-1:0]          eu_reg;
    logic [CW-1:0]          su_reg;
    logic [CW-1:0]          seed_i_reg;
    logic [CW-1:0]          head_reg;
    logic [CW-1:0]          tail_reg;
    logic [CW-1:0]          popped_reg;
    logic [EW-1:0]          e_reg;
    logic                   out_valid_reg;
    logic                   count_paths_reg;
    logic [2:0]             cmd_next;
    logic [9:0]             a_next;
    logic [9:0]             b_next;
    logic                   use_t_next;
    logic                   graph_sweep_next;
    logic [NW-1:0]          sweep_cnt_next;
    logic [EW-1:0]          eu_next;
    logic [CW-1:0]          su_next;
    logic [CW-1:0]          seed_i_next;
    logic [CW-1:0]          head_next;
    logic [CW-1:0]          tail_next;
    logic [CW-1:0]          popped_next;
    logic [EW-1:0]          e_next;
    logic                   out_valid_next;

    // payload registers
    logic [NW-1:0]          u_dist_reg;
    logic [COUNT_WIDTH-1:0] u_paths_reg;
    logic [NW-1:0]          v_reg;
    bfs_pkg::out_t          res_reg;
    bfs_pkg::out_t          out_data_reg;
    logic [NW-1:0]          u_dist_next;
    logic [COUNT_WIDTH-1:0] u_paths_next;
    logic [NW-1:0]          v_next;
    bfs_pkg::out_t          res_next;
    bfs_pkg::out_t          out_data_next;

    // derived values
    logic [NW-1:0]          a_idx;
    logic [NW-1:0]          b_idx;
    logic                   a_ok;
    logic                   b_ok;
    logic                   vis_q;
    logic [NW-1:0]          dist_q;
    logic [COUNT_WIDTH-1:0] paths_q;
    logic [NW:0]            u_dist_inc;
    logic [COUNT_WIDTH:0]   path_sum;
    logic [COUNT_WIDTH-1:0] path_sat;

    assign a_idx   = NW'(a_reg);
    assign b_idx   = NW'(b_reg);
    assign a_ok    = 32'(a_reg) < 32'(MAX_NODES);
    assign b_ok    = 32'(b_reg) < 32'(MAX_NODES);
    assign vis_q   = info_q[IW-1];
    assign dist_q  = info_q[IW-2 -: NW];
    assign paths_q = info_q[COUNT_WIDTH-1:0];
    assign u_dist_inc = {1'b0, u_dist_reg} + {{NW{1'b0}}, 1'b1};
    assign path_sum   = {1'b0, paths_q} + {1'b0, u_paths_reg};
    assign path_sat   = path_sum[COUNT_WIDTH] ? {COUNT_WIDTH{1'b1}}
                                              : path_sum[COUNT_WIDTH-1:0];

    always_comb
    begin
        stat.cmd        = cmd_reg;
        stat.a_ok       = a_ok;
        stat.ab_ok      = a_ok && b_ok;
        stat.edge_full  = (eu_reg == EW'(MAX_EDGES));
        stat.sweep_last = (sweep_cnt_reg == NW'(MAX_NODES - 1));
        stat.seed_more  = (seed_i_reg < su_reg);
        stat.queue_more = (head_reg < tail_reg);
        stat.hit_target = use_t_reg && a_ok && (queue_q == a_idx);
        stat.edge_more  = (e_reg < eu_reg);
        stat.out_free   = !out_valid_reg || out_ready;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        cmd_next         = cmd_reg;
        a_next           = a_reg;
        b_next           = b_reg;
        use_t_next       = use_t_reg;
        graph_sweep_next = graph_sweep_reg;
        sweep_cnt_next   = sweep_cnt_reg;
        eu_next          = eu_reg;
        su_next          = su_reg;
        seed_i_next      = seed_i_reg;
        head_next        = head_reg;
        tail_next        = tail_reg;
        popped_next      = popped_reg;
        e_next           = e_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        u_dist_next      = u_dist_reg;
        u_paths_next     = u_paths_reg;
        v_next           = v_reg;
        res_next         = res_reg;
        out_data_next    = out_data_reg;

        dest_we = 1'b0;
        dest_wa = eu_reg[EAW-1:0];
        dest_re = 1'b0;
        dest_ra = e_reg[EAW-1:0];
        next_we = 1'b0;
        next_wa = eu_reg[EAW-1:0];
        next_wd = EMPTY;
        ah_we   = 1'b0;
        ah_wa   = sweep_cnt_reg;
        ah_wd   = EMPTY;
        ah_re   = 1'b0;
        at_we   = 1'b0;
        at_wa   = sweep_cnt_reg;
        at_wd   = EMPTY;
        at_re   = 1'b0;
        src_we  = 1'b0;
        src_re  = 1'b0;
        info_we = 1'b0;
        info_wa = sweep_cnt_reg;
        info_wd = '0;
        info_re = 1'b0;
        info_ra = a_idx;
        q_we    = 1'b0;
        q_re    = 1'b0;

        case (op)
            bfs_pkg::OP_LOAD:
            begin
                cmd_next         = in_data.command;
                a_next           = in_data.node_a;
                b_next           = in_data.node_b;
                use_t_next       = in_data.use_target;
                graph_sweep_next = (in_data.command == bfs_pkg::CMD_CLEAR);
                sweep_cnt_next   = '0;
                seed_i_next      = '0;
                head_next        = '0;
                tail_next        = '0;
                popped_next      = '0;
                res_next         = '0;
            end
            bfs_pkg::OP_CLR_CNT:
            begin
                eu_next = '0;
                su_next = '0;
            end
            bfs_pkg::OP_SRC:
            begin
                if (su_reg == CW'(MAX_NODES))
                begin
                    res_next.status = bfs_pkg::ST_SRC_FULL;
                end
                else if (a_ok)
                begin
                    src_we  = 1'b1;
                    su_next = su_reg + 1'b1;
                end
            end
            bfs_pkg::OP_EDGE_FULL:
            begin
                res_next.status = bfs_pkg::ST_EDGE_FULL;
            end
            bfs_pkg::OP_SWEEP:
            begin
                info_we        = 1'b1;
                ah_we          = graph_sweep_reg;
                at_we          = graph_sweep_reg;
                sweep_cnt_next = sweep_cnt_reg + 1'b1;
            end
            bfs_pkg::OP_SEED_RD:
            begin
                src_re      = 1'b1;
                seed_i_next = seed_i_reg + 1'b1;
            end
            bfs_pkg::OP_SEED_INFO:
            begin
                info_re = 1'b1;
                info_ra = src_q;
            end
            bfs_pkg::OP_SEED_WR:
            begin
                if (!vis_q)
                begin
                    info_we   = 1'b1;
                    info_wa   = src_q;
                    info_wd   = {1'b1, {NW{1'b0}}, COUNT_WIDTH'(count_paths_reg)};
                    q_we      = 1'b1;
                    v_next    = src_q;
                    tail_next = tail_reg + 1'b1;
                end
            end
            bfs_pkg::OP_POP:
            begin
                q_re        = 1'b1;
                head_next   = head_reg + 1'b1;
                popped_next = popped_reg + 1'b1;
            end
            bfs_pkg::OP_U_RD:
            begin
                info_re = 1'b1;
                info_ra = queue_q;
                ah_re   = 1'b1;
            end
            bfs_pkg::OP_U_LATCH:
            begin
                u_dist_next  = dist_q;
                u_paths_next = paths_q;
                e_next       = head_q;
            end
            bfs_pkg::OP_E_RD:
            begin
                dest_re = 1'b1;
            end
            bfs_pkg::OP_V_RD:
            begin
                info_re = 1'b1;
                info_ra = dest_q;
                v_next  = dest_q;
                e_next  = next_q;
            end
            bfs_pkg::OP_V_UPD:
            begin
                info_wa = v_reg;
                if (!vis_q)
                begin
                    info_we   = 1'b1;
                    info_wd   = {1'b1, u_dist_inc[NW-1:0],
                                 count_paths_reg ? u_paths_reg : {COUNT_WIDTH{1'b0}}};
                    q_we      = 1'b1;
                    tail_next = tail_reg + 1'b1;
                end
                else if (count_paths_reg && ({1'b0, dist_q} == u_dist_inc))
                begin
                    info_we = 1'b1;
                    info_wd = {1'b1, dist_q, path_sat};
                end
            end
            bfs_pkg::OP_QRD:
            begin
                info_re = 1'b1;
            end
            bfs_pkg::OP_Q_RES:
            begin
                if (vis_q)
                begin
                    res_next.reached    = 1'b1;
                    res_next.distance   = 10'(dist_q);
                    res_next.path_count = 32'(paths_q);
                end
            end
            bfs_pkg::OP_AE1:
            begin
                dest_we = 1'b1;
                next_we = 1'b1;
                at_re   = 1'b1;
            end
            bfs_pkg::OP_AE2:
            begin
                at_we = 1'b1;
                at_wa = a_idx;
                at_wd = eu_reg;
                if (tail_q == EMPTY)
                begin
                    ah_we = 1'b1;
                    ah_wa = a_idx;
                    ah_wd = eu_reg;
                end
                else
                begin
                    next_we = 1'b1;
                    next_wa = tail_q[EAW-1:0];
                    next_wd = eu_reg;
                end
                eu_next = eu_reg + 1'b1;
            end
            bfs_pkg::OP_EMIT:
            begin
                out_valid_next = 1'b1;
                out_data_next  = res_reg;
                out_data_next.nodes_dequeued =
                    (cmd_reg == bfs_pkg::CMD_RUN) ? 11'(popped_reg) : 11'd0;
            end
            default:
            begin
                out_valid_next = out_valid_reg && !out_ready;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_reg         <= bfs_pkg::CMD_CLEAR;
            a_reg           <= '0;
            b_reg           <= '0;
            use_t_reg       <= 1'b0;
            graph_sweep_reg <= 1'b1;
            sweep_cnt_reg   <= '0;
            eu_reg          <= '0;
            su_reg          <= '0;
            seed_i_reg      <= '0;
            head_reg        <= '0;
            tail_reg        <= '0;
            popped_reg      <= '0;
            e_reg           <= '0;
            out_valid_reg   <= 1'b0;
            count_paths_reg <= 1'b1;
        end
        else
        begin
            cmd_reg         <= cmd_next;
            a_reg           <= a_next;
            b_reg           <= b_next;
            use_t_reg       <= use_t_next;
            graph_sweep_reg <= graph_sweep_next;
            sweep_cnt_reg   <= sweep_cnt_next;
            eu_reg          <= eu_next;
            su_reg          <= su_next;
            seed_i_reg      <= seed_i_next;
            head_reg        <= head_next;
            tail_reg        <= tail_next;
            popped_reg      <= popped_next;
            e_reg           <= e_next;
            out_valid_reg   <= out_valid_next;
            if (cfg_we)
            begin
                count_paths_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        u_dist_reg   <= u_dist_next;
        u_paths_reg  <= u_paths_next;
        v_reg        <= v_next;
        res_reg      <= res_next;
        out_data_reg <= out_data_next;
    end

    // memories
    always_ff @(posedge clk)
    begin
        if (dest_we)
        begin
            edge_dest_mem[dest_wa] <= b_idx;
        end
        if (dest_re)
        begin
            dest_q <= edge_dest_mem[dest_ra];
        end
    end

    always_ff @(posedge clk)
    begin
        if (next_we)
        begin
            edge_next_mem[next_wa] <= next_wd;
        end
        if (dest_re)
        begin
            next_q <= edge_next_mem[dest_ra];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ah_we)
        begin
            adj_head_mem[ah_wa] <= ah_wd;
        end
        if (ah_re)
        begin
            head_q <= adj_head_mem[queue_q];
        end
    end

    always_ff @(posedge clk)
    begin
        if (at_we)
        begin
            adj_tail_mem[at_wa] <= at_wd;
        end
        if (at_re)
        begin
            tail_q <= adj_tail_mem[a_idx];
        end
    end

    always_ff @(posedge clk)
    begin
        if (src_we)
        begin
            source_mem[su_reg[NW-1:0]] <= a_idx;
        end
        if (src_re)
        begin
            src_q <= source_mem[seed_i_reg[NW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (info_we)
        begin
            info_mem[info_wa] <= info_wd;
        end
        if (info_re)
        begin
            info_q <= info_mem[info_ra];
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_we)
        begin
            queue_mem[tail_reg[NW-1:0]] <= (op == bfs_pkg::OP_SEED_WR) ? src_q : v_reg;
        end
        if (q_re)
        begin
            queue_q <= queue_mem[head_reg[NW-1:0]];
        end
    end

endmodule

// ===== sv/bfs_distance_path_count_core.sv =====
// top level: breadth-first search core with hop distance and shortest path counting
//
//  channel   direction  handshake              payload
//  in        input      in_valid / in_ready    in_data   (bfs_pkg::in_t)
//  out       output     out_valid / out_ready  out_data  (bfs_pkg::out_t)
//  cfg       input      cfg_we                 cfg_wdata (count_paths)
//
// transactions: one at a time; clear graph sweeps every node; run sweeps every node to
//   clear the results, seeds each listed source, then dequeues nodes and scans their
//   edges until the queue empties or a target is dequeued, which stops the search
// the node memory is read on every visit, then written when the visit changes it
// reset: a clearing pass over every node empties the adjacency heads and tails and
//   the node results; in_ready stays low meanwhile, cfg writes are taken as ever
// stalls: a finished result sits in the output register, the next transaction is taken
//   while it waits; only the following result waits on out_ready
module bfs_distance_path_count_core #(
    parameter int MAX_NODES   = 1024,
    parameter int MAX_EDGES   = 4096,
    parameter int COUNT_WIDTH = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  bfs_pkg::in_t  in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output bfs_pkg::out_t out_data,
    input  logic          cfg_we,
    input  logic          cfg_wdata
);

    // command and status between controller and datapath
    bfs_pkg::dp_op_t   op;
    bfs_pkg::dp_stat_t stat;

    bfs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .op       (op)
    );

    // memories, counters, count_paths register and the output register
    bfs_dpath #(
        .MAX_NODES   (MAX_NODES),
        .MAX_EDGES   (MAX_EDGES),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .op        (op),
        .stat      (stat),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

endmodule

// ===== sv/bfs_chk.sv =====
// checker: port-level assertions for the bfs core, bound to the top level
module bfs_chk (
    input logic          clk,
    input logic          rst_n,
    input logic          in_valid,
    input logic          in_ready,
    input logic          out_valid,
    input logic          out_ready,
    input bfs_pkg::out_t out_data
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result dropped or changed while stalled");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second transaction taken while one is in flight");

    a_status_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.status != bfs_pkg::ST_OK) |->
            !out_data.reached && (out_data.nodes_dequeued == 11'd0))
        else $error("error status with query or run fields set");

    a_unreached_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.reached |->
            (out_data.distance == 10'd0) && (out_data.path_count == 32'd0))
        else $error("unreached node reports distance or paths");

endmodule

bind bfs_distance_path_count_core bfs_chk u_bfs_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

// ===== tb/sv/bfs_distance_path_count_core_tb.sv =====
// testbench for the bfs distance and path count core: predicted results checked per transaction
`timescale 1ns / 1ps

module bfs_distance_path_count_core_tb;

    localparam int NODES = 1024;
    localparam int EDGES = 4096;
    localparam int EMPTY = EDGES;

    logic          clk;
    logic          rst_n;
    logic          in_valid;
    logic          in_ready;
    bfs_pkg::in_t  in_data;
    logic          out_valid;
    logic          out_ready;
    bfs_pkg::out_t out_data;
    logic          cfg_we;
    logic          cfg_wdata;

    bfs_distance_path_count_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // predictor state, mirrors the graph and the last search
    int          g_dest [EDGES];
    int          g_next [EDGES];
    int          g_head [NODES];
    int          g_tail [NODES];
    int          g_edges;
    int          g_srcs [NODES];
    int          g_nsrc;
    bit          g_seen [NODES];
    int          g_hops [NODES];
    logic [31:0] g_paths [NODES];
    int          g_fifo [NODES];
    bit          g_count_on;

    bfs_pkg::out_t expected_q [$];
    int            errors;
    bit            rx_stall_enable;

    always #6 clk = ~clk;

    // ---------------- predictor ----------------

    function automatic void forget_results();
        for (int i = 0; i < NODES; i++)
        begin
            g_seen[i]  = 0;
            g_hops[i]  = 0;
            g_paths[i] = '0;
        end
    endfunction

    function automatic void wipe_graph();
        for (int i = 0; i < NODES; i++)
        begin
            g_head[i] = EMPTY;
            g_tail[i] = EMPTY;
        end
        g_edges = 0;
        g_nsrc  = 0;
        forget_results();
    endfunction

    function automatic int bfs_walk(bit stop_on, int goal);
        int rd;
        int wr;
        int popped;
        int u;
        int e;
        int v;
        logic [32:0] sum;
        rd = 0;
        wr = 0;
        popped = 0;
        forget_results();
        // seed every distinct listed source at distance zero
        for (int i = 0; i < g_nsrc; i++)
        begin
            u = g_srcs[i];
            if (!g_seen[u])
            begin
                g_seen[u]  = 1;
                g_hops[u]  = 0;
                g_paths[u] = g_count_on ? 32'd1 : 32'd0;
                if (wr < NODES)
                    g_fifo[wr++] = u;
            end
        end
        while (rd < wr)
        begin
            u = g_fifo[rd++];
            popped++;
            if (stop_on && u == goal)
                break;
            e = g_head[u];
            while (e < g_edges && e < EDGES)
            begin
                v = g_dest[e];
                if (!g_seen[v])
                begin
                    g_seen[v] = 1;
                    g_hops[v] = g_hops[u] + 1;
                    if (g_count_on)
                        g_paths[v] = g_paths[u];
                    if (wr < NODES)
                        g_fifo[wr++] = v;
                end
                else if (g_count_on && g_hops[v] == g_hops[u] + 1)
                begin
                    // saturating sum of the path counts
                    sum = {1'b0, g_paths[v]} + {1'b0, g_paths[u]};
                    g_paths[v] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
                end
                e = g_next[e];
            end
        end
        return popped;
    endfunction

    function automatic bfs_pkg::out_t predict_result(bfs_pkg::in_t t);
        bfs_pkg::out_t r;
        int a;
        int b;
        a = t.node_a;
        b = t.node_b;
        r = '0;
        case (t.command)
            bfs_pkg::CMD_CLEAR:
                wipe_graph();
            bfs_pkg::CMD_ADD_EDGE:
            begin
                if (g_edges >= EDGES)
                    r.status = bfs_pkg::ST_EDGE_FULL;
                else
                begin
                    g_dest[g_edges] = b;
                    g_next[g_edges] = EMPTY;
                    if (g_tail[a] == EMPTY)
                        g_head[a] = g_edges;
                    else
                        g_next[g_tail[a]] = g_edges;
                    g_tail[a] = g_edges;
                    g_edges++;
                end
            end
            bfs_pkg::CMD_ADD_SRC:
            begin
                if (g_nsrc >= NODES)
                    r.status = bfs_pkg::ST_SRC_FULL;
                else
                    g_srcs[g_nsrc++] = a;
            end
            bfs_pkg::CMD_RUN:
                r.nodes_dequeued = 11'(bfs_walk(t.use_target, a));
            bfs_pkg::CMD_QUERY:
            begin
                if (g_seen[a])
                begin
                    r.reached    = 1'b1;
                    r.distance   = 10'(g_hops[a]);
                    r.path_count = g_paths[a];
                end
            end
            default:
                ;
        endcase
        return r;
    endfunction

    // ---------------- driving ----------------

    // entered at a falling edge; valid stays high into the next call when it has no gap
    task automatic send_item(logic [2:0] cmd, int a, int b, bit tgt);
        bfs_pkg::in_t t;
        int gap;
        gap = (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11));
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            in_data  <= bfs_pkg::in_t'($urandom);
            repeat (gap) @(negedge clk);
        end
        t.command    = cmd;
        t.node_a     = 10'(a);
        t.node_b     = 10'(b);
        t.use_target = tgt;
        in_data  <= t;
        in_valid <= 1'b1;
        // wait for the accepting edge
        do
            @(posedge clk);
        while (!in_ready);
        expected_q.insert(expected_q.size(), predict_result(t));
        @(negedge clk);
    endtask

    // output side: random stall per transaction
    initial
    begin
        int hold;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            hold = rx_stall_enable ? $urandom_range(0, 11) : 0;
            if (hold != 0)
            begin
                out_ready <= 1'b0;
                repeat (hold) @(negedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
        end
    end

    // result checker: one field at a time against the oldest expectation
    always @(posedge clk)
    begin
        bfs_pkg::out_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_q.size() == 0)
            begin
                $display("%0t unexpected transaction: expected none, actual %h", $time, out_data);
                errors++;
            end
            else
            begin
                e = expected_q.pop_front();
                if (out_data.status !== e.status)
                begin
                    $display("%0t status: expected %0d, actual %0d", $time, e.status,
                             out_data.status);
                    errors++;
                end
                if (out_data.reached !== e.reached)
                begin
                    $display("%0t reached: expected %0d, actual %0d", $time, e.reached,
                             out_data.reached);
                    errors++;
                end
                if (out_data.distance !== e.distance)
                begin
                    $display("%0t distance: expected %0d, actual %0d", $time, e.distance,
                             out_data.distance);
                    errors++;
                end
                if (out_data.path_count !== e.path_count)
                begin
                    $display("%0t path_count: expected %0d, actual %0d", $time,
                             e.path_count, out_data.path_count);
                    errors++;
                end
                if (out_data.nodes_dequeued !== e.nodes_dequeued)
                begin
                    $display("%0t nodes_dequeued: expected %0d, actual %0d", $time,
                             e.nodes_dequeued, out_data.nodes_dequeued);
                    errors++;
                end
            end
        end
    end

    // idle point for register writes: input released, every result drained
    task automatic drain();
        in_valid <= 1'b0;
        while (expected_q.size() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    task automatic set_count_paths(bit v);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we    <= 1'b0;
        g_count_on = v;
    endtask

    // ---------------- tests ----------------

    // field extremes, every command, duplicate source, unused codes
    task automatic test_directed();
        send_item(bfs_pkg::CMD_QUERY, 0, 0, 0);
        send_item(bfs_pkg::CMD_RUN, 0, 0, 0);
        send_item(bfs_pkg::CMD_ADD_EDGE, 0, 1023, 0);
        send_item(bfs_pkg::CMD_ADD_EDGE, 0, 1, 1);
        send_item(bfs_pkg::CMD_ADD_EDGE, 1, 2, 0);
        send_item(bfs_pkg::CMD_ADD_EDGE, 1023, 2, 0);
        send_item(bfs_pkg::CMD_ADD_EDGE, 2, 0, 0);
        send_item(bfs_pkg::CMD_ADD_SRC, 0, 1023, 0);
        send_item(bfs_pkg::CMD_ADD_SRC, 0, 0, 0);
        send_item(bfs_pkg::CMD_RUN, 1023, 0, 0);
        send_item(bfs_pkg::CMD_QUERY, 2, 0, 0);
        send_item(bfs_pkg::CMD_QUERY, 1023, 0, 0);
        send_item(bfs_pkg::CMD_QUERY, 5, 0, 0);
        send_item(bfs_pkg::CMD_RUN, 1023, 0, 1);
        send_item(bfs_pkg::CMD_RUN, 5, 0, 1);
        send_item(3'd5, 1023, 1023, 1);
        send_item(3'd6, 0, 0, 0);
        send_item(3'd7, 1023, 1023, 1);
        send_item(bfs_pkg::CMD_QUERY, 0, 0, 1);
        send_item(bfs_pkg::CMD_CLEAR, 1023, 1023, 1);
        send_item(bfs_pkg::CMD_QUERY, 2, 0, 0);
        send_item(bfs_pkg::CMD_RUN, 0, 0, 0);
    endtask

    // chain of triple parallel edges: path counts triple per hop, saturate past hop 20
    task automatic test_saturation();
        send_item(bfs_pkg::CMD_CLEAR, 0, 0, 0);
        for (int s = 0; s < 21; s++)
        begin
            repeat (3)
                send_item(bfs_pkg::CMD_ADD_EDGE, s, s + 1, 0);
        end
        send_item(bfs_pkg::CMD_ADD_SRC, 0, 0, 0);
        send_item(bfs_pkg::CMD_RUN, 0, 0, 0);
        send_item(bfs_pkg::CMD_QUERY, 20, 0, 0);
        send_item(bfs_pkg::CMD_QUERY, 21, 0, 0);
    endtask

    // random graphs on few nodes, then searches and queries
    task automatic test_random_graphs(int rounds);
        int span;
        for (int r = 0; r < rounds; r++)
        begin
            span = ($urandom_range(0, 4) == 0) ? 1023 : $urandom_range(4, 12);
            send_item(bfs_pkg::CMD_CLEAR, $urandom_range(0, 1023), $urandom_range(0, 1023), 0);
            repeat ($urandom_range(3, 10))
                send_item(bfs_pkg::CMD_ADD_EDGE, $urandom_range(0, span),
                          $urandom_range(0, span), $urandom_range(0, 1));
            repeat ($urandom_range(1, 2))
                send_item(bfs_pkg::CMD_ADD_SRC, $urandom_range(0, span),
                          $urandom_range(0, 1023), $urandom_range(0, 1));
            send_item(bfs_pkg::CMD_RUN, $urandom_range(0, span), $urandom_range(0, 1023),
                      $urandom_range(0, 1));
            repeat ($urandom_range(2, 4))
                send_item(bfs_pkg::CMD_QUERY, $urandom_range(0, span),
                          $urandom_range(0, 1023), $urandom_range(0, 1));
            if ($urandom_range(0, 5) == 0)
                send_item(3'($urandom_range(5, 7)), $urandom, $urandom, $urandom_range(0, 1));
        end
    endtask

    initial
    begin
        errors          = 0;
        rx_stall_enable = 1'b1;
        clk       = 1'b0;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        cfg_we    = 1'b0;
        cfg_wdata = 1'b0;
        g_count_on = 1'b1;
        wipe_graph();
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_saturation();
        set_count_paths(1'b0);
        test_random_graphs(1);
        set_count_paths(1'b1);
        // stretch without output stalls
        rx_stall_enable = 1'b0;
        test_random_graphs(1);
        rx_stall_enable = 1'b1;

        drain();
        if (errors == 0 && expected_q.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // watchdog
    initial
    begin
        #(12 * 3_000_000);
        $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/bfs_pkg.sv
sv/bfs_ctrl.sv
sv/bfs_dpath.sv
sv/bfs_distance_path_count_core.sv
sv/bfs_chk.sv
tb/sv/bfs_distance_path_count_core_tb.sv
